[rtl/core/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the scanline unfilter unit
// Filter codes, lane control, configuration register indexes and sizes.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int LANES              = 4;
    localparam int BYTE_W             = 8;
    localparam int PIXEL_W            = LANES * BYTE_W;
    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 16384;

    localparam int CFG_WIDTH_W   = 13;
    localparam int CFG_HEIGHT_W  = 15;
    localparam int CFG_CHAN_W    = 3;
    localparam int CFG_DATA_W    = 15;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    typedef struct packed {
        filter_t filt;
        logic    en;
    } lane_ctl_t;

    // Codes above Paeth behave as None.
    function automatic filter_t decode_filter(input logic [BYTE_W-1:0] code);
        filter_t f;
        unique case (code)
            8'd1:    f = FLT_SUB;
            8'd2:    f = FLT_UP;
            8'd3:    f = FLT_AVG;
            8'd4:    f = FLT_PAETH;
            default: f = FLT_NONE;
        endcase
        return f;
    endfunction

    function automatic logic [BYTE_W:0] abs_diff9(input logic [BYTE_W:0] x,
                                                  input logic [BYTE_W:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

endpackage

[rtl/core/png_scanline_unfilter_unit.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit: PNG scanline filter reconstruction, 8-bit samples
// An accepted input is registered in the compute stage, then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store read is
// issued at acceptance and its registered data feeds the following compute stage.
// Reset: asynchronous, active low; clears position, filter, neighbors, valids
// and sets width 1, height 1, four channels. The line store is not cleared.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit #(
    parameter int MAX_WIDTH  = psu_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = psu_pkg::DEFAULT_MAX_HEIGHT,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [psu_pkg::BYTE_W-1:0]     raw_ch0,
    input  logic [psu_pkg::BYTE_W-1:0]     raw_ch1,
    input  logic [psu_pkg::BYTE_W-1:0]     raw_ch2,
    input  logic [psu_pkg::BYTE_W-1:0]     raw_ch3,
    input  logic [psu_pkg::BYTE_W-1:0]     line_filter,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [psu_pkg::BYTE_W-1:0]     recon_ch0,
    output logic [psu_pkg::BYTE_W-1:0]     recon_ch1,
    output logic [psu_pkg::BYTE_W-1:0]     recon_ch2,
    output logic [psu_pkg::BYTE_W-1:0]     recon_ch3,
    output logic [COL_W-1:0]               pixel_column,
    output logic [ROW_W-1:0]               pixel_row,
    output logic                           last_of_image
);
    import psu_pkg::*;

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = ($clog2(MAX_DIM + 1) > 16) ? $clog2(MAX_DIM + 1) : 16;

    // Configuration registers.
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_CHAN_W-1:0]   chan_reg;

    logic [DIM_W-1:0]      w_eff;
    logic [DIM_W-1:0]      h_eff;
    logic [CFG_CHAN_W-1:0] nch_eff;

    // Position and filter state at the input side.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    filter_t          cur_filt_reg;
    filter_t          in_filt;
    logic [DIM_W-1:0] col_p1;
    logic [DIM_W-1:0] row_p1;
    logic             last_col;
    logic             last_row;

    // Compute stage.
    logic                 s1_valid_reg;
    logic [BYTE_W-1:0]    s1_raw_reg [LANES];
    filter_t              s1_filt_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic                 s1_last_reg;
    logic [LANES-1:0]     s1_en_reg;
    logic                 s1_left_zero_reg;
    logic                 s1_up_zero_reg;
    logic                 byp_hit_reg;
    logic [PIXEL_W-1:0]   byp_data_reg;
    logic [PIXEL_W-1:0]   left_reg;
    logic [PIXEL_W-1:0]   ul_reg;

    // Output register.
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pix_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic               out_last_reg;

    logic               in_accept;
    logic               s1_adv;
    logic [PIXEL_W-1:0] ram_q;
    logic [PIXEL_W-1:0] up_pix;
    logic [PIXEL_W-1:0] left_pix;
    logic [PIXEL_W-1:0] ul_pix;
    logic [PIXEL_W-1:0] result;
    logic [BYTE_W-1:0]  raw_in [LANES];

    assign raw_in[0] = raw_ch0;
    assign raw_in[1] = raw_ch1;
    assign raw_in[2] = raw_ch2;
    assign raw_in[3] = raw_ch3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_W'(1);
            height_reg <= CFG_HEIGHT_W'(1);
            chan_reg   <= CFG_CHAN_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[CFG_CHAN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Out-of-range sizes are clamped to the supported range.
    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DIM_W'(width_reg);
        end

        priority if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = DIM_W'(height_reg);
        end

        priority if (chan_reg == '0)
        begin
            nch_eff = CFG_CHAN_W'(1);
        end
        else if (chan_reg > CFG_CHAN_W'(LANES))
        begin
            nch_eff = CFG_CHAN_W'(LANES);
        end
        else
        begin
            nch_eff = chan_reg;
        end
    end

    // Handshake.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // Position counters advance at acceptance.
    assign col_p1   = DIM_W'(col_reg) + DIM_W'(1);
    assign row_p1   = DIM_W'(row_reg) + DIM_W'(1);
    assign last_col = col_p1 >= w_eff;
    assign last_row = row_p1 >= h_eff;
    assign in_filt  = (col_reg == '0) ? decode_filter(line_filter) : cur_filt_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_p1[ROW_W-1:0];
            end
            else
            begin
                col_next = col_p1[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            cur_filt_reg <= FLT_NONE;
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
            left_reg     <= '0;
            ul_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_accept)
            begin
                cur_filt_reg <= in_filt;
                // The pixel ahead writes the address being read this cycle.
                byp_hit_reg  <= s1_adv && (s1_col_reg == col_reg);
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                left_reg      <= result;
                ul_reg        <= up_pix;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                s1_raw_reg[i] <= raw_in[i];
                s1_en_reg[i]  <= CFG_CHAN_W'(i) < nch_eff;
            end
            s1_filt_reg      <= in_filt;
            s1_col_reg       <= col_reg;
            s1_row_reg       <= row_reg;
            s1_last_reg      <= last_col && last_row;
            s1_left_zero_reg <= (col_reg == '0);
            s1_up_zero_reg   <= (row_reg == '0);
            byp_data_reg     <= result;
        end
        if (s1_adv)
        begin
            out_pix_reg  <= result;
            out_col_reg  <= s1_col_reg;
            out_row_reg  <= s1_row_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    psu_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (result),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_q)
    );

    // Neighbors outside the image count as zero.
    assign up_pix   = s1_up_zero_reg ? '0 : (byp_hit_reg ? byp_data_reg : ram_q);
    assign left_pix = s1_left_zero_reg ? '0 : left_reg;
    assign ul_pix   = (s1_left_zero_reg || s1_up_zero_reg) ? '0 : ul_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        lane_ctl_t ctl;

        assign ctl.filt = s1_filt_reg;
        assign ctl.en   = s1_en_reg[g];

        psu_lane u_lane (
            .ctl (ctl),
            .x   (s1_raw_reg[g]),
            .a   (left_pix[g*BYTE_W +: BYTE_W]),
            .b   (up_pix[g*BYTE_W +: BYTE_W]),
            .c   (ul_pix[g*BYTE_W +: BYTE_W]),
            .y   (result[g*BYTE_W +: BYTE_W])
        );
    end

    assign out_valid     = out_valid_reg;
    assign recon_ch0     = out_pix_reg[0*BYTE_W +: BYTE_W];
    assign recon_ch1     = out_pix_reg[1*BYTE_W +: BYTE_W];
    assign recon_ch2     = out_pix_reg[2*BYTE_W +: BYTE_W];
    assign recon_ch3     = out_pix_reg[3*BYTE_W +: BYTE_W];
    assign pixel_column  = out_col_reg;
    assign pixel_row     = out_row_reg;
    assign last_of_image = out_last_reg;

    // A pixel leaving the compute stage is presented at the output next cycle.
    a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid)
        else $error("compute stage advanced but output not valid");

    // Lanes beyond the channel count deliver zero.
    a_unused_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && nch_eff < CFG_CHAN_W'(LANES)) |-> (recon_ch3 == '0))
        else $error("unused lane carries data");

    // The final pixel of an image returns the position to the origin.
    a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not wrap after last pixel");

endmodule

[rtl/core/psu_ram.sv]
// ----------------------------------------------------------------------------
// psu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/psu_lane.sv]
// ----------------------------------------------------------------------------
// psu_lane: reconstruction of one 8-bit channel
// Forms the None/Sub/Up/Average/Paeth predictor and adds it modulo 256.
// ----------------------------------------------------------------------------
module psu_lane (
    input  psu_pkg::lane_ctl_t        ctl,
    input  logic [psu_pkg::BYTE_W-1:0] x,
    input  logic [psu_pkg::BYTE_W-1:0] a,
    input  logic [psu_pkg::BYTE_W-1:0] b,
    input  logic [psu_pkg::BYTE_W-1:0] c,
    output logic [psu_pkg::BYTE_W-1:0] y
);
    import psu_pkg::*;

    logic [BYTE_W:0]   sum_ab;
    logic [BYTE_W:0]   pa;
    logic [BYTE_W:0]   pb;
    logic [BYTE_W:0]   pc;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W-1:0] pred;

    assign sum_ab = {1'b0, a} + {1'b0, b};

    // Distances of a+b-c to each neighbor; ties prefer left, then above.
    assign pa = abs_diff9({1'b0, b}, {1'b0, c});
    assign pb = abs_diff9({1'b0, a}, {1'b0, c});
    assign pc = abs_diff9(sum_ab, {c, 1'b0});

    always_comb
    begin
        priority if (pa <= pb && pa <= pc)
        begin
            paeth = a;
        end
        else if (pb <= pc)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end
    end

    always_comb
    begin
        unique case (ctl.filt)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = sum_ab[BYTE_W:1];
            FLT_PAETH: pred = paeth;
            default:   pred = '0;
        endcase
    end

    assign y = ctl.en ? (x + pred) : '0;

endmodule

[dv/png_scanline_unfilter_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit_tb: self-checking bench for the scanline unfilter
// Raster-order pixels go in through a bursty driver while the output side
// stalls on its own pattern. Every accepted pixel is rebuilt by a local
// predictor (None, Sub, Up, Average, Paeth, neighbors outside the image as
// zero) and the rebuilt pixels are compared in order with the unit's output.
// Image sizes and channel counts change between phases, also mid-image.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit_tb;

    import psu_pkg::*;

    localparam int MAX_W        = DEFAULT_MAX_WIDTH;
    localparam int MAX_H        = DEFAULT_MAX_HEIGHT;
    localparam int ITEM_TARGET  = 1450;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_REPORTS  = 10;
    localparam logic [7:0] EDGE_BYTES [4] = '{8'h00, 8'hFF, 8'h80, 8'h01};

    typedef struct packed {
        logic [3:0][7:0] raw;
        logic [7:0]      flt;
    } pix_in_t;

    typedef struct packed {
        logic [3:0][7:0] lane;
        logic [11:0]     col;
        logic [13:0]     row;
        logic            last_px;
    } pix_out_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] raw_ch0 = '0;
    logic [7:0] raw_ch1 = '0;
    logic [7:0] raw_ch2 = '0;
    logic [7:0] raw_ch3 = '0;
    logic [7:0] line_filter = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] recon_ch0;
    logic [7:0] recon_ch1;
    logic [7:0] recon_ch2;
    logic [7:0] recon_ch3;
    logic [11:0] pixel_column;
    logic [13:0] pixel_row;
    logic last_of_image;

    png_scanline_unfilter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_ch0       (raw_ch0),
        .raw_ch1       (raw_ch1),
        .raw_ch2       (raw_ch2),
        .raw_ch3       (raw_ch3),
        .line_filter   (line_filter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .recon_ch0     (recon_ch0),
        .recon_ch1     (recon_ch1),
        .recon_ch2     (recon_ch2),
        .recon_ch3     (recon_ch3),
        .pixel_column  (pixel_column),
        .pixel_row     (pixel_row),
        .last_of_image (last_of_image)
    );

    // Predictor state: previous scanline, neighbors, position and registers.
    logic [31:0] prev_line [MAX_W];
    logic [31:0] left_q = '0;
    logic [31:0] upleft_q = '0;
    logic [7:0]  row_filter = '0;
    int          cur_col = 0;
    int          cur_row = 0;
    logic [12:0] reg_width = 13'd1;
    logic [14:0] reg_height = 15'd1;
    logic [2:0]  reg_chans = 3'd4;

    pix_in_t  pending_px [$];
    pix_out_t expected_px [$];
    int       pixels_queued = 0;
    int       pixels_accepted = 0;
    int       errors = 0;
    int       cycles = 0;
    logic     in_fire = 1'b0;

    function automatic int clamp_size(int value, int limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Pixels still to go in the current image, with wrap at a stale position.
    function automatic int pixels_to_image_end(int col, int row, int w, int h);
        int this_row;
        int rows_left;
        this_row = (col + 1 >= w) ? 1 : w - col;
        rows_left = (row + 1 >= h) ? 0 : h - row - 1;
        return this_row + rows_left * w;
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0)
            return EDGE_BYTES[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_filter();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, int'(FLT_PAETH)));
    endfunction

    task automatic reconstruct_pixel(input pix_in_t px, output pix_out_t res);
        int w;
        int h;
        int nch;
        int col;
        int row;
        int a;
        int b;
        int c;
        int pa;
        int pb;
        int pc;
        int pred;
        logic [31:0] left_v;
        logic [31:0] up_v;
        logic [31:0] ul_v;
        logic [31:0] pix;
        filter_t f;
        w = clamp_size(int'(reg_width), MAX_W);
        h = clamp_size(int'(reg_height), MAX_H);
        nch = clamp_size(int'(reg_chans), LANES);
        col = cur_col;
        row = cur_row;
        left_v = (col > 0) ? left_q : '0;
        up_v = (row > 0) ? prev_line[col % MAX_W] : '0;
        ul_v = (col > 0 && row > 0) ? upleft_q : '0;
        if (col == 0)
            row_filter = px.flt;
        // Codes above Paeth rebuild as None.
        f = (row_filter > 8'(FLT_PAETH)) ? FLT_NONE : filter_t'(row_filter[2:0]);
        pix = '0;
        for (int i = 0; i < LANES; i++)
        begin
            a = left_v[8*i +: 8];
            b = up_v[8*i +: 8];
            c = ul_v[8*i +: 8];
            unique case (f)
                FLT_SUB: pred = a;
                FLT_UP:  pred = b;
                FLT_AVG: pred = (a + b) / 2;
                FLT_PAETH:
                begin
                    pa = (b > c) ? b - c : c - b;
                    pb = (a > c) ? a - c : c - a;
                    pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
                    if (pa <= pb && pa <= pc)
                        pred = a;
                    else if (pb <= pc)
                        pred = b;
                    else
                        pred = c;
                end
                default: pred = 0;
            endcase
            if (i < nch)
                pix[8*i +: 8] = 8'(int'(px.raw[i]) + pred);
        end
        res.lane = pix;
        res.col = 12'(col);
        res.row = 14'(row);
        res.last_px = (col + 1 >= w) && (row + 1 >= h);
        prev_line[col % MAX_W] = pix;
        upleft_q = up_v;
        left_q = pix;
        if (col + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (row + 1 >= h) ? 0 : row + 1;
        end
        else
        begin
            cur_col = col + 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            CFG_IMAGE_WIDTH:   reg_width = 13'(value);
            CFG_IMAGE_HEIGHT:  reg_height = 15'(value);
            CFG_CHANNEL_COUNT: reg_chans = 3'(value);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (!(pending_px.size() == 0 && !in_valid && expected_px.size() == 0))
            @(posedge clk);
    endtask

    task automatic queue_random_pixels(input int n);
        pix_in_t p;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < LANES; i++)
                p.raw[i] = rand_byte();
            p.flt = rand_filter();
            pending_px.push_back(p);
        end
        pixels_queued += n;
    endtask

    // Registers are only touched once the unit has gone quiet.
    task automatic run_phase(input int w, input int h, input int ch, input int n);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, ch);
        queue_random_pixels(n);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: a new pixel goes out only when the previous one was taken.
    always @(negedge clk)
    begin
        pix_in_t p;
        int burst_left;
        int gap_left;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_px.size() > 0)
            begin
                p = pending_px.pop_front();
                raw_ch0 <= p.raw[0];
                raw_ch1 <= p.raw[1];
                raw_ch2 <= p.raw[2];
                raw_ch3 <= p.raw[3];
                line_filter <= p.flt;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random modes, plus two long holds to back the unit up.
    // A hold starts only while the sender still has pixels to offer.
    always @(negedge clk)
    begin
        int hold_left;
        int next_hold;
        int mode;
        int mode_left;
        if (next_hold == 0)
            next_hold = 400;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (pixels_accepted >= next_hold && next_hold < 1400 &&
                 pending_px.size() > 4)
        begin
            hold_left = HOLD_CYCLES;
            next_hold += 600;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            unique case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: predict on each input transaction, check each output one.
    always @(posedge clk)
    begin
        pix_in_t seen;
        pix_out_t want;
        pix_out_t got;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            seen.raw[0] = raw_ch0;
            seen.raw[1] = raw_ch1;
            seen.raw[2] = raw_ch2;
            seen.raw[3] = raw_ch3;
            seen.flt = line_filter;
            reconstruct_pixel(seen, want);
            expected_px.push_back(want);
            pixels_accepted++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.lane = {recon_ch3, recon_ch2, recon_ch1, recon_ch0};
            got.col = pixel_column;
            got.row = pixel_row;
            got.last_px = last_of_image;
            if (expected_px.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output pixel: lanes %h col %0d row %0d last %b",
                             got.lane, got.col, got.row, got.last_px);
            end
            else
            begin
                want = expected_px.pop_front();
                if (got.lane !== want.lane || got.col !== want.col ||
                    got.row !== want.row || got.last_px !== want.last_px)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"pixel mismatch: expected lanes %h col %0d row %0d last %b,",
                                  " got lanes %h col %0d row %0d last %b"},
                                 want.lane, want.col, want.row, want.last_px,
                                 got.lane, got.col, got.row, got.last_px);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        pix_in_t p;
        logic [7:0] row_codes [6];
        int w;
        int h;
        int to_end;
        int n;
        int span;
        row_codes = '{8'd255, 8'(FLT_SUB), 8'(FLT_UP), 8'(FLT_AVG), 8'(FLT_PAETH),
                      8'(FLT_NONE)};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes: every pixel is a whole one-pixel image.
        p.raw = {8'hFF, 8'h00, 8'h80, 8'h01};
        p.flt = 8'(FLT_SUB);
        pending_px.push_back(p);
        p.raw = {8'h00, 8'hFF, 8'h01, 8'h80};
        p.flt = 8'd255;
        pending_px.push_back(p);

        // Six rows of three, one filter per row, edge bytes throughout.
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 6);
        write_reg(CFG_CHANNEL_COUNT, 4);
        for (int k = 0; k < 18; k++)
        begin
            for (int i = 0; i < LANES; i++)
                p.raw[i] = EDGE_BYTES[(k * (i + 1) + i) % 4];
            p.flt = (k % 3 == 0) ? row_codes[k / 3] : rand_filter();
            pending_px.push_back(p);
        end
        pixels_queued = 20;

        // Out-of-range sizes, then a mid-image shrink that wraps the column.
        run_phase(0, 0, 0, 6);
        run_phase(8191, 32767, 7, 40);
        run_phase(4096, 16384, 4, 30);
        wait_drained();
        run_phase(16, 3, 3, pixels_to_image_end(cur_col, cur_row, 16, 3));

        while (pixels_queued < ITEM_TARGET)
        begin
            wait_drained();
            if (cur_col == 0 && cur_row == 0)
            begin
                span = $urandom_range(0, 99);
                if (span < 65)
                    w = $urandom_range(1, 8);
                else if (span < 90)
                    w = $urandom_range(9, 40);
                else if (span < 95)
                    w = 0;
                else
                    w = $urandom_range(MAX_W, 8191);
            end
            else
            begin
                // Mid-image the width may only shrink, so the row above is
                // always fully written where it is read.
                span = clamp_size(int'(reg_width), MAX_W);
                w = $urandom_range(0, (span < 40) ? span : 40);
            end
            span = $urandom_range(0, 99);
            if (span < 70)
                h = $urandom_range(1, 5);
            else if (span < 85)
                h = $urandom_range(6, 12);
            else if (span < 92)
                h = 0;
            else
                h = $urandom_range(MAX_H, 32767);
            to_end = pixels_to_image_end(cur_col, cur_row, clamp_size(w, MAX_W),
                                         clamp_size(h, MAX_H));
            if (to_end > 1 && (to_end > 150 || $urandom_range(0, 3) == 0))
                n = $urandom_range(1, (to_end - 1 < 60) ? to_end - 1 : 60);
            else
                n = to_end;
            run_phase(w, h, $urandom_range(0, 7), n);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_px.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
